// ----- hw/rtl/itad_pkg.sv -----
// itad_pkg: shared types and constants for the integer to ascii digits block
// state encodings, the conversion handoff struct and the digit character map
// no dependencies
package itad_pkg;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SKIP,
    EM_SIGN,
    EM_EMIT
  } emit_state_t;

  // conversion result handed from the converter to the emitter
  typedef struct packed {
    logic valid;
    logic neg;
  } hand_ctl_t;

  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam int unsigned FUNC_HEX_BIT = 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else begin
      c = CHAR_A + {4'b0000, d} - {4'b0000, DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/itad_conv.sv -----
// itad_conv: bit-serial binary to bcd converter (shift and add three)
// hex mode loads the nibbles directly; signed mode negates negative values first
// depends on itad_pkg
module itad_conv #(
  parameter int VW   = 32,
  parameter int NDIG = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start_valid,
  output logic                   start_ready,
  input  logic [VW-1:0]          value,
  input  logic [1:0]             func,
  output logic [4*NDIG-1:0]      digits,
  output itad_pkg::hand_ctl_t    hand,
  input  logic                   take
);
  import itad_pkg::*;

  localparam int CW = $clog2(VW);

  conv_state_t        state_r, state_nxt;
  logic [VW-1:0]      bin_r, bin_nxt;
  logic [4*NDIG-1:0]  bcd_r, bcd_nxt;
  logic [4*NDIG-1:0]  adj;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic               neg_in;
  logic [VW-1:0]      mag;

  assign neg_in = (func == FUNC_SDEC) && value[VW-1];
  assign mag    = neg_in ? (VW'(0) - value) : value;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    case (state_r)
      CV_IDLE: begin
        if (start_valid) begin
          neg_nxt = neg_in;
          bin_nxt = mag;
          cnt_nxt = CW'(VW - 1);
          if (func[FUNC_HEX_BIT]) begin
            bcd_nxt   = {{(4*NDIG-VW){1'b0}}, value};
            state_nxt = CV_DONE;
          end else begin
            bcd_nxt   = '0;
            state_nxt = CV_RUN;
          end
        end
      end
      CV_RUN: begin
        bcd_nxt = {adj[4*NDIG-2:0], bin_r[VW-1]};
        bin_nxt = {bin_r[VW-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = CV_DONE;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      CV_DONE: begin
        if (take) begin
          state_nxt = CV_IDLE;
        end
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  assign start_ready = (state_r == CV_IDLE);
  assign digits      = bcd_r;
  assign hand.valid  = (state_r == CV_DONE);
  assign hand.neg    = neg_r;

endmodule

// ----- hw/rtl/itad_emit.sv -----
// itad_emit: digit shift register that drops leading zeros and sends characters
// one beat per cycle while out_ready holds, through a registered output stage
// depends on itad_pkg
module itad_emit #(
  parameter int NDIG = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [4*NDIG-1:0]      digits,
  input  itad_pkg::hand_ctl_t    hand,
  output logic                   take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_char,
  output logic                   out_last
);
  import itad_pkg::*;

  localparam int LW = $clog2(NDIG + 1);

  emit_state_t        state_r, state_nxt;
  logic [4*NDIG-1:0]  dig_r, dig_nxt;
  logic [LW-1:0]      left_r, left_nxt;
  logic               neg_r, neg_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic               slot;
  logic [3:0]         top;

  assign slot = !ov_r || out_ready;
  assign top  = dig_r[4*NDIG-1 -: 4];

  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    left_nxt  = left_r;
    neg_nxt   = neg_r;
    ov_nxt    = ov_r && !out_ready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    case (state_r)
      EM_IDLE: begin
        if (hand.valid) begin
          dig_nxt   = digits;
          left_nxt  = LW'(NDIG);
          neg_nxt   = hand.neg;
          state_nxt = EM_SKIP;
        end
      end
      EM_SKIP: begin
        // zero keeps its last digit
        if (top == 4'd0 && left_r != LW'(1)) begin
          dig_nxt  = dig_r << 4;
          left_nxt = left_r - LW'(1);
        end else begin
          state_nxt = neg_r ? EM_SIGN : EM_EMIT;
        end
      end
      EM_SIGN: begin
        if (slot) begin
          ov_nxt    = 1'b1;
          oc_nxt    = CHAR_MINUS;
          ol_nxt    = 1'b0;
          state_nxt = EM_EMIT;
        end
      end
      EM_EMIT: begin
        if (slot) begin
          ov_nxt   = 1'b1;
          oc_nxt   = digit_char(top);
          ol_nxt   = (left_r == LW'(1));
          dig_nxt  = dig_r << 4;
          left_nxt = left_r - LW'(1);
          if (left_r == LW'(1)) begin
            state_nxt = EM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    left_r <= left_nxt;
    neg_r  <= neg_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign take      = (state_r == EM_IDLE) && hand.valid;
  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

endmodule

// ----- hw/rtl/integer_to_ascii_digits_top.sv -----
// integer_to_ascii_digits_top: number to ascii text, signed/unsigned decimal or hex
// decimal: the bcd converter runs, then the emitter skips k leading zeros (0..NDIG-1) before
// the first beat; hex loads the nibbles directly; characters then leave at one beat per cycle
// while out_tready holds; a new item is taken once the converter hands its result on,
// so conversion overlaps emission; the converter (decimal) or emitter (hex) sets the item rate
// reset: synchronous active-low rst_n clears both state machines and the output valid
module integer_to_ascii_digits_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      in_tdata,   // value
  input  logic [1:0]                            in_tuser,   // func
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // ascii_char
  output logic                                  out_tlast
);
  import itad_pkg::*;

  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

  logic [4*NDIG-1:0] digits;
  hand_ctl_t         hand;
  logic              take;

  itad_conv #(
    .VW   (VALUE_WIDTH),
    .NDIG (NDIG)
  ) u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_valid (in_tvalid),
    .start_ready (in_tready),
    .value       (in_tdata[VALUE_WIDTH-1:0]),
    .func        (in_tuser),
    .digits      (digits),
    .hand        (hand),
    .take        (take)
  );

  itad_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .digits    (digits),
    .hand      (hand),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("converter took a beat while not idle");

  a_handoff_once: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !hand.valid)
    else $error("conversion result offered twice");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata == CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign marked as last character");
`endif

endmodule
